[src/assert_macros.svh]
// assertion macros used by the port-level checker ctbb_chk
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is active
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked assertion that is also checked during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

[src/ctbb_pkg.sv]
// types and constants for the countdown timer with bcd display
// no dependencies
package ctbb_pkg;

    localparam int TIME_W    = 27;
    localparam int MODE_W    = 2;
    localparam int PHASE_W   = 3;
    localparam int RED_W     = 18;
    localparam int GREEN_W   = 8;
    localparam int BCD_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int MAX_SHOWN = BCD_W / 4;
    localparam int STEP_W    = $clog2(TIME_W);
    localparam int STEP_LAST = TIME_W - 1;

    localparam logic [PHASE_W-1:0] PHASE_MAX = 3'd7;
    localparam logic [RED_W-1:0]   RED_ALL   = 18'h3FFFF;
    localparam logic [GREEN_W-1:0] GREEN_ALL = 8'hFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_COUNT = 2'd0,
        MODE_RED   = 2'd1,
        MODE_GREEN = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_TIME = 1'b0,
        CFG_START_MODE = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;      // take the tick, update state, start conversion
        logic step;      // one double-dabble step
        logic out_load;  // move the finished result into the output register
    } t_cmd;

endpackage

[src/ctbb_ctrl.sv]
// controller: handshake and sequencing of one tick through the bcd converter
// depends on ctbb_pkg
module ctbb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ctbb_pkg::t_cmd o_cmd
);
    import ctbb_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        // transfer on the output side frees the register
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == STEP_W'(STEP_LAST)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[src/ctbb_dp.sv]
// datapath: timer state, config registers, bit-serial bcd converter, output register
// depends on ctbb_pkg
module ctbb_dp #(
    parameter int TICKS_PER_SECOND = 4,
    parameter int KEEP_DIGITS      = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ctbb_pkg::t_cmd                  i_cmd,
    input  logic                            i_timed_out,
    input  logic                            i_cfg_we,
    input  logic [ctbb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ctbb_pkg::TIME_W-1:0]     i_cfg_data,
    output logic [ctbb_pkg::BCD_W-1:0]      o_display_bcd,
    output logic [ctbb_pkg::RED_W-1:0]      o_red_leds,
    output logic [ctbb_pkg::GREEN_W-1:0]    o_green_leds,
    output logic                            o_expired
);
    import ctbb_pkg::*;

    localparam int KW = KEEP_DIGITS * 4;
    localparam logic [PHASE_W-1:0] FULL_PH = PHASE_W'(TICKS_PER_SECOND);
    localparam logic [PHASE_W-1:0] HALF_PH = PHASE_W'((TICKS_PER_SECOND + 1) / 2);

    logic [TIME_W-1:0]  r_remaining, n_remaining;
    logic               r_expired, n_expired;
    t_mode              r_mode, n_mode;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic               r_red_on, n_red_on;
    logic               r_green_on, n_green_on;

    logic [TIME_W-1:0]  r_shift, n_shift;
    logic [KW-1:0]      r_bcd, n_bcd;
    logic [KW-1:0]      adj;

    logic [BCD_W-1:0]   r_out_bcd;
    logic               r_out_red;
    logic               r_out_green;
    logic               r_out_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_expired   <= 1'b0;
            r_mode      <= MODE_COUNT;
            r_phase     <= '0;
            r_red_on    <= 1'b0;
            r_green_on  <= 1'b0;
        end else begin
            r_remaining <= n_remaining;
            r_expired   <= n_expired;
            r_mode      <= n_mode;
            r_phase     <= n_phase;
            r_red_on    <= n_red_on;
            r_green_on  <= n_green_on;
        end
    end

    // tick update and config writes
    always_comb begin
        logic [PHASE_W-1:0] ph;
        n_remaining = r_remaining;
        n_expired   = r_expired;
        n_mode      = r_mode;
        n_red_on    = r_red_on;
        n_green_on  = r_green_on;
        ph          = r_phase;
        if (i_cmd.load) begin
            if (i_timed_out && r_mode == MODE_COUNT && r_phase == FULL_PH) begin
                if (r_remaining != '0) begin
                    n_remaining = r_remaining - 1'b1;
                end else begin
                    n_expired = 1'b1;
                    n_mode    = MODE_RED;
                end
                ph = '0;
            end else if (i_timed_out && r_mode == MODE_RED) begin
                if (r_phase == HALF_PH) begin
                    n_red_on = ~r_red_on;
                    ph       = '0;
                end
            end else if (i_timed_out && r_mode == MODE_GREEN) begin
                n_green_on = ~r_green_on;
                ph         = '0;
            end
            if (ph < PHASE_MAX) begin
                ph = ph + 1'b1;
            end
        end
        n_phase = ph;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_TIME: begin
                    n_remaining = i_cfg_data;
                    n_expired   = 1'b0;
                end
                CFG_START_MODE: begin
                    // the unused mode code keeps the mode but still clears expired
                    if (i_cfg_data[MODE_W-1:0] <= MODE_GREEN) begin
                        n_mode = t_mode'(i_cfg_data[MODE_W-1:0]);
                    end
                    n_expired = 1'b0;
                end
                default: begin
                    n_expired = r_expired;
                end
            endcase
        end
    end

    // double dabble, one bit per step; only the low digits are kept
    always_comb begin
        logic [3:0] dig;
        for (int k = 0; k < KEEP_DIGITS; k++) begin
            dig          = r_bcd[k*4 +: 4];
            adj[k*4 +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
        n_shift = r_shift;
        n_bcd   = r_bcd;
        if (i_cmd.load) begin
            n_shift = n_remaining;
            n_bcd   = '0;
        end else if (i_cmd.step) begin
            n_shift = {r_shift[TIME_W-2:0], 1'b0};
            n_bcd   = {adj[KW-2:0], r_shift[TIME_W-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
        if (i_cmd.out_load) begin
            r_out_bcd   <= BCD_W'(r_bcd);
            r_out_red   <= r_red_on;
            r_out_green <= r_green_on;
            r_out_exp   <= r_expired;
        end
    end

    assign o_display_bcd = r_out_bcd;
    assign o_red_leds    = r_out_red ? RED_ALL : '0;
    assign o_green_leds  = r_out_green ? GREEN_ALL : '0;
    assign o_expired     = r_out_exp;

endmodule

[src/countdown_timer_bcd_blink.sv]
// Countdown timer with packed-bcd display and blinking led words. Each input
// transfer is one interval-timer tick carrying its timeout flag; each tick gives
// exactly one result with the remaining time in bcd, the red and green led words
// and the expired flag. For each tick the block takes the tick and updates the
// timer state, runs 27 steps of the bit-serial binary-to-bcd converter (one
// per bit of the 27-bit remaining time), and loads the output register. That
// load waits as long as an earlier result is held in the output register by
// the output stall. The next tick is taken while a finished result still waits
// in the output register. Config writes reload the time or the mode; the user
// makes them only while no tick is in progress, the block does not enforce it.
// depends on ctbb_pkg, ctbb_ctrl, ctbb_dp
module countdown_timer_bcd_blink #(
    parameter int BCD_DIGITS       = 8,
    parameter int TICKS_PER_SECOND = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_timed_out,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ctbb_pkg::BCD_W-1:0]      o_display_bcd,
    output logic [ctbb_pkg::RED_W-1:0]      o_red_leds,
    output logic [ctbb_pkg::GREEN_W-1:0]    o_green_leds,
    output logic                            o_expired,
    input  logic                            i_cfg_we,
    input  logic [ctbb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ctbb_pkg::TIME_W-1:0]     i_cfg_data
);
    import ctbb_pkg::*;

    // digits above the eighth fall outside the 32-bit display word
    localparam int KEEP_DIGITS = (BCD_DIGITS < MAX_SHOWN) ? BCD_DIGITS : MAX_SHOWN;

    t_cmd cmd;

    ctbb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    ctbb_dp #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .KEEP_DIGITS      (KEEP_DIGITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_timed_out   (i_timed_out),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_display_bcd (o_display_bcd),
        .o_red_leds    (o_red_leds),
        .o_green_leds  (o_green_leds),
        .o_expired     (o_expired)
    );

endmodule

[src/ctbb_chk.sv]
// port-level checks for the countdown timer, bound to the top level
// depends on ctbb_pkg and assert_macros.svh
`include "assert_macros.svh"

module ctbb_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [ctbb_pkg::BCD_W-1:0]    o_display_bcd,
    input logic [ctbb_pkg::RED_W-1:0]    o_red_leds,
    input logic [ctbb_pkg::GREEN_W-1:0]  o_green_leds,
    input logic                          o_expired
);
    import ctbb_pkg::*;

    // reset leaves no result pending and the input side open
    `ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_stall))

    // led words are all off or all on whenever a result is valid
    `ASSERT_CLK(a_red_word, i_clk, i_rst_n, o_out_valid |-> (o_red_leds == '0 || o_red_leds == RED_ALL))
    `ASSERT_CLK(a_green_word, i_clk, i_rst_n, o_out_valid |-> (o_green_leds == '0 || o_green_leds == GREEN_ALL))

    // a stalled result holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_display_bcd) && $stable(o_expired)))

endmodule

bind countdown_timer_bcd_blink ctbb_chk u_ctbb_chk (.*);

[bench/ctbb_checker.sv]
`timescale 1ns / 100ps
// result checker for countdown_timer_bcd_blink: follows register writes and tick
// transfers, predicts every result and compares it with what the block returns
// depends on ctbb_pkg
module ctbb_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic                            i_timed_out,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [ctbb_pkg::BCD_W-1:0]      i_display_bcd,
    input  logic [ctbb_pkg::RED_W-1:0]      i_red_leds,
    input  logic [ctbb_pkg::GREEN_W-1:0]    i_green_leds,
    input  logic                            i_expired,
    input  logic                            i_cfg_we,
    input  logic [ctbb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ctbb_pkg::TIME_W-1:0]     i_cfg_data,
    output int                              o_mismatches,
    output int                              o_pending,
    output int                              o_checked,
    output int                              o_expiries
);
    import ctbb_pkg::*;

    localparam int DIGITS        = 8;
    localparam int TICKS_PER_SEC = 4;
    localparam logic [PHASE_W-1:0] SECOND_PHASE = PHASE_W'(TICKS_PER_SEC);
    localparam logic [PHASE_W-1:0] BLINK_PHASE  = PHASE_W'((TICKS_PER_SEC + 1) / 2);
    localparam int PRINT_LIMIT   = 40;

    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [RED_W-1:0]   red;
        logic [GREEN_W-1:0] green;
        logic               expired;
    } t_shown;

    logic [TIME_W-1:0]  secs_left;
    logic               expired_q;
    t_mode              mode_q;
    logic [PHASE_W-1:0] phase_q;
    logic               red_q;
    logic               green_q;
    t_shown             shown_due[$];
    int                 mismatches = 0;
    int                 checked    = 0;
    int                 expiries   = 0;

    function automatic logic [BCD_W-1:0] bcd_of(input logic [TIME_W-1:0] secs);
        logic [BCD_W-1:0] acc;
        int unsigned      v;
        int               d;
        acc = '0;
        v   = secs;
        for (d = 0; d < DIGITS && d < MAX_SHOWN; d++) begin
            acc[d*4 +: 4] = 4'(v % 10);
            v = v / 10;
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        // keep the log short when the block is badly off
        if (mismatches <= PRINT_LIMIT)
            $display("ctbb_checker: %0t: %s: got %h, want %h", $realtime, what, got, want);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
        logic [MODE_W-1:0] m;
        m = data[MODE_W-1:0];
        if (idx == CFG_START_TIME) begin
            secs_left = data;
            expired_q = 1'b0;
        end else begin
            // the unused mode code keeps the mode but still clears expired
            if (m <= MODE_GREEN)
                mode_q = t_mode'(m);
            expired_q = 1'b0;
        end
    endtask

    task automatic take_tick(input logic to);
        t_shown s;
        if (to && mode_q == MODE_COUNT && phase_q == SECOND_PHASE) begin
            if (secs_left != '0) begin
                secs_left = secs_left - 1'b1;
            end else begin
                expired_q = 1'b1;
                mode_q    = MODE_RED;
                expiries++;
            end
            phase_q = '0;
        end else if (to && mode_q == MODE_RED) begin
            if (phase_q == BLINK_PHASE) begin
                red_q   = ~red_q;
                phase_q = '0;
            end
        end else if (to && mode_q == MODE_GREEN) begin
            green_q = ~green_q;
            phase_q = '0;
        end
        // phase saturates, so a missed match stalls the countdown for good
        if (phase_q < PHASE_MAX)
            phase_q = phase_q + 1'b1;
        s.bcd     = bcd_of(secs_left);
        s.red     = red_q ? RED_ALL : '0;
        s.green   = green_q ? GREEN_ALL : '0;
        s.expired = expired_q;
        shown_due.push_back(s);
    endtask

    task automatic compare_shown();
        t_shown want;
        if (shown_due.size() == 0) begin
            report_mismatch("result with nothing expected", i_display_bcd, '0);
        end else begin
            want = shown_due.pop_front();
            checked++;
            if (i_display_bcd !== want.bcd)
                report_mismatch("display_bcd", i_display_bcd, want.bcd);
            if (i_red_leds !== want.red)
                report_mismatch("red_leds", i_red_leds, want.red);
            if (i_green_leds !== want.green)
                report_mismatch("green_leds", i_green_leds, want.green);
            if (i_expired !== want.expired)
                report_mismatch("expired", i_expired, want.expired);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            secs_left = '0;
            expired_q = 1'b0;
            mode_q    = MODE_COUNT;
            phase_q   = '0;
            red_q     = 1'b0;
            green_q   = 1'b0;
            shown_due.delete();
        end else begin
            if (i_cfg_we)
                write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !i_in_stall)
                take_tick(i_timed_out);
            if (i_out_valid && !i_out_stall)
                compare_shown();
        end
        o_mismatches <= mismatches;
        o_pending    <= shown_due.size();
        o_checked    <= checked;
        o_expiries   <= expiries;
    end

endmodule

[bench/tb_countdown_timer_bcd_blink.sv]
`timescale 1ns / 100ps
// testbench top for countdown_timer_bcd_blink: drives ticks and register writes,
// stalls the result side and gives the verdict
// depends on ctbb_pkg, countdown_timer_bcd_blink, ctbb_checker
module tb_countdown_timer_bcd_blink;
    import ctbb_pkg::*;

    localparam int RANDOM_TICKS = 1000;
    localparam int LONG_HOLD    = 400;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE       = 64;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef enum int {
        WR_TIME,
        WR_MODE,
        WR_BOTH
    } t_write_set;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    logic                   i_timed_out = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [BCD_W-1:0]       o_display_bcd;
    logic [RED_W-1:0]       o_red_leds;
    logic [GREEN_W-1:0]     o_green_leds;
    logic                   o_expired;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_START_TIME;
    logic [TIME_W-1:0]      i_cfg_data  = '0;

    int mismatches;
    int pending;
    int checked;
    int expiries;
    int hold_req      = 0;
    int hold_done     = 0;
    int burst_left    = 0;
    int ticks_sent    = 0;
    int settings_made = 0;
    int quiet_cycles  = 0;

    always #5 i_clk = ~i_clk;

    countdown_timer_bcd_blink dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_timed_out   (i_timed_out),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_display_bcd (o_display_bcd),
        .o_red_leds    (o_red_leds),
        .o_green_leds  (o_green_leds),
        .o_expired     (o_expired),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    ctbb_checker result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_timed_out   (i_timed_out),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_display_bcd (o_display_bcd),
        .i_red_leds    (o_red_leds),
        .i_green_leds  (o_green_leds),
        .i_expired     (o_expired),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_expiries    (expiries)
    );

    // mode register word with random upper bits, only the low bits count
    function automatic logic [TIME_W-1:0] mode_word(input logic [MODE_W-1:0] m);
        logic [TIME_W-1:0] w;
        w = TIME_W'($urandom);
        w[MODE_W-1:0] = m;
        return w;
    endfunction

    // one tick transfer; the sender runs in bursts with random gaps between them
    task automatic send_tick(input logic to);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_timed_out <= to;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
        ticks_sent++;
    endtask

    // lsb first
    task automatic send_run(input logic [15:0] bits, input int n);
        int k;
        for (k = 0; k < n; k++)
            send_tick(bits[k]);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [TIME_W-1:0] secs, input logic [TIME_W-1:0] mw,
                            input t_write_set which);
        if (which != WR_MODE) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_START_TIME;
            i_cfg_data  <= secs;
            @(posedge i_clk);
        end
        if (which != WR_TIME) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_START_MODE;
            i_cfg_data  <= mw;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings_made++;
    endtask

    // result-side stall pattern, with a long hold-off whenever one is requested
    initial begin : receiver
        int pat;
        int pat_left;
        int cyc;
        pat_left = 0;
        pat      = 0;
        cyc      = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_req != hold_done) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_done++;
            end else begin
                if (pat_left == 0) begin
                    pat      = $urandom_range(0, 3);
                    pat_left = $urandom_range(20, 200);
                end
                pat_left--;
                case (pat)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= (cyc % 7) < 3;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("tb_countdown_timer_bcd_blink: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [TIME_W-1:0] secs;
        logic [MODE_W-1:0] md;
        t_write_set        which;
        int                random_ticks;
        int                seg;
        int                len;
        int                zero_odds;
        logic              to;

        random_ticks = 0;
        seg          = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // from reset: zero time expires on the first matched second, then red blinks
        send_run(16'b1_1111_1110, 9);
        drain();
        // largest shown value counts down by one
        set_regs(TIME_W'(99999999), mode_word(MODE_COUNT), WR_BOTH);
        send_run(16'b1111, 4);
        drain();
        // oversized time and the unused mode code, then a missed second stalls the phase
        set_regs({TIME_W{1'b1}}, mode_word(MODE_UNUSED), WR_BOTH);
        send_run(16'b11_0111_1111, 10);
        drain();
        // green toggles on every timed-out tick, whatever the phase
        set_regs('0, mode_word(MODE_GREEN), WR_BOTH);
        send_run(16'b101, 3);

        while (random_ticks < RANDOM_TICKS) begin
            drain();
            case ($urandom_range(0, 9))
                0:       secs = '0;
                1, 2, 3, 4: secs = TIME_W'($urandom_range(0, 8));
                5, 6:    secs = TIME_W'($urandom_range(0, 300));
                7:       secs = TIME_W'(99999999);
                8:       secs = {TIME_W{1'b1}};
                default: secs = TIME_W'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: md = MODE_COUNT;
                6, 7:    md = MODE_RED;
                8:       md = MODE_GREEN;
                default: md = MODE_UNUSED;
            endcase
            case ($urandom_range(0, 5))
                0:       which = WR_TIME;
                1:       which = WR_MODE;
                default: which = WR_BOTH;
            endcase
            // a green tick brings a saturated phase back to the start
            if (md != MODE_GREEN && $urandom_range(0, 3) != 0) begin
                set_regs('0, mode_word(MODE_GREEN), WR_MODE);
                send_tick(1'b1);
                drain();
                which = WR_BOTH;
            end
            set_regs(secs, mode_word(md), which);
            case ($urandom_range(0, 7))
                5, 6:    zero_odds = 16;
                7:       zero_odds = 2;
                default: zero_odds = 0;
            endcase
            len = $urandom_range(4, 60);
            if (seg == 3 || seg == 14) begin
                hold_req++;
                len = 60;
            end
            repeat (len) begin
                to = (zero_odds == 0) ? 1'b1 : ($urandom_range(0, zero_odds - 1) != 0);
                send_tick(to);
            end
            random_ticks += len;
            seg++;
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        $display("summary: %0d ticks sent over %0d register settings, %0d long result holds",
                 ticks_sent, settings_made, hold_done);
        $display("summary: %0d results compared, %0d countdown expiries predicted",
                 checked, expiries);
        if (mismatches == 0 && pending == 0)
            $display("tb_countdown_timer_bcd_blink: clean");
        else
            $display("tb_countdown_timer_bcd_blink: errors");
        $finish;
    end

endmodule
